/* sv/tase_pkg.sv */
// Shared constants for the tour annealing swap engine.
// No dependencies; imported by tour_annealing_swap_engine_unit.
package tase_pkg;

    localparam int MAX_CITIES = 256;
    localparam int CITY_AW    = $clog2(MAX_CITIES);
    localparam int TOUR_AW    = $clog2(MAX_CITIES + 1);
    localparam int COUNT_W    = 9;

    localparam logic [39:0] COST_MAX = 40'hFF_FFFF_FFFF;
    localparam logic [31:0] ONE_Q24  = 32'd16777216;
    localparam logic [31:0] BASE_Q24 = 32'd45298483;
    localparam logic [6:0]  PERCENT  = 7'd100;
    localparam logic [19:0] Q_CAP    = 20'd327680;

    localparam logic [1:0] ACT_LOAD  = 2'd0;
    localparam logic [1:0] ACT_START = 2'd1;
    localparam logic [1:0] ACT_STEP  = 2'd2;
    localparam logic [1:0] ACT_NOP   = 2'd3;

    localparam logic [1:0] CFG_CITY_COUNT = 2'd0;
    localparam logic [1:0] CFG_INIT_TEMP  = 2'd1;
    localparam logic [1:0] CFG_DECAY      = 2'd2;

    localparam logic [8:0]  RST_CITY_COUNT = 9'd256;
    localparam logic [31:0] RST_INIT_TEMP  = 32'd6553600;
    localparam logic [31:0] RST_DECAY      = 32'd4294966866;

endpackage

/* sv/tour_annealing_swap_engine_unit.sv */
// Tour annealing swap engine: city store, tour store, sequencer and shared datapath.
// Depends on tase_pkg.
//
// A load request writes one city and goes straight to the result. A start
// request sums the length of the tour. A valid step request prices the changed
// edges, then, where needed, a bit-serial division and an exponential of up to 16
// square roots and 20 multiplies. The 25-step square root unit and the single
// 32x32 multiplier are shared: the root by edge pricing and the exponential,
// the multiplier by edge pricing, the exponential and the temperature decay.
module tour_annealing_swap_engine_unit
    import tase_pkg::*;
(
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_cfg_we,
    input  logic [1:0]         i_cfg_index,
    input  logic [31:0]        i_cfg_data,
    input  logic               i_in_valid,
    output logic               o_in_ready,
    input  logic [1:0]         i_action,
    input  logic [7:0]         i_city_index,
    input  logic signed [15:0] i_coord_x,
    input  logic signed [15:0] i_coord_y,
    input  logic [7:0]         i_swap_position,
    input  logic [6:0]         i_random_percent,
    output logic               o_out_valid,
    input  logic               i_out_ready,
    output logic               o_accepted,
    output logic               o_bad_position,
    output logic [39:0]        o_tour_cost,
    output logic [39:0]        o_least_cost
);

    localparam logic [4:0] S_IDLE    = 5'd0;
    localparam logic [4:0] S_DONE    = 5'd1;
    localparam logic [4:0] S_ST_RD   = 5'd2;
    localparam logic [4:0] S_ST_CAP  = 5'd3;
    localparam logic [4:0] S_ST_SUM  = 5'd4;
    localparam logic [4:0] S_ST_END  = 5'd5;
    localparam logic [4:0] S_SW_TRD  = 5'd6;
    localparam logic [4:0] S_SW_TCAP = 5'd7;
    localparam logic [4:0] S_SW_CRD  = 5'd8;
    localparam logic [4:0] S_SW_CCAP = 5'd9;
    localparam logic [4:0] S_SW_ESET = 5'd10;
    localparam logic [4:0] S_SW_EACC = 5'd11;
    localparam logic [4:0] S_SW_NC   = 5'd12;
    localparam logic [4:0] S_SW_CHK  = 5'd13;
    localparam logic [4:0] S_DIV     = 5'd14;
    localparam logic [4:0] S_DIV_END = 5'd15;
    localparam logic [4:0] S_PW_SQ   = 5'd16;
    localparam logic [4:0] S_PW_MUL  = 5'd17;
    localparam logic [4:0] S_PW_INT  = 5'd18;
    localparam logic [4:0] S_PW_CMP  = 5'd19;
    localparam logic [4:0] S_AP1     = 5'd20;
    localparam logic [4:0] S_AP2     = 5'd21;
    localparam logic [4:0] S_DEC1    = 5'd22;
    localparam logic [4:0] S_DEC2    = 5'd23;
    localparam logic [4:0] S_E_MX    = 5'd24;
    localparam logic [4:0] S_E_MY    = 5'd25;
    localparam logic [4:0] S_SQ      = 5'd26;

    logic [4:0]  r_state, r_ret;
    logic [8:0]  r_city_count;
    logic [31:0] r_init_temp, r_decay;
    logic [39:0] r_cost, r_best, r_acc, r_next;
    logic [63:0] r_temp;
    logic [7:0]  r_pos;
    logic [6:0]  r_rnd;
    logic        r_res_acc, r_res_bad;
    logic        r_out_valid;

    logic [8:0]  r_i;
    logic [1:0]  r_k;
    logic [7:0]  r_t  [0:3];
    logic signed [15:0] r_cx [0:3];
    logic signed [15:0] r_cy [0:3];
    logic signed [15:0] r_ux, r_uy, r_vx, r_vy;
    logic signed [27:0] r_dsum;
    logic [33:0] r_sq;

    logic [49:0] r_sq_op;
    logic [29:0] r_sq_rem;
    logic [24:0] r_sq_res;
    logic [4:0]  r_sq_cnt;

    logic        r_neg, r_dzero;
    logic [39:0] r_m;
    logic [63:0] r_rem;
    logic [19:0] r_q;
    logic [6:0]  r_div_cnt;

    logic [31:0] r_e;
    logic [25:0] r_root;
    logic [3:0]  r_b;
    logic [2:0]  r_kk;
    logic [63:0] r_prod;

    logic signed [15:0] mem_x [0:MAX_CITIES-1];
    logic signed [15:0] mem_y [0:MAX_CITIES-1];
    logic [7:0]         mem_tour [0:MAX_CITIES];
    logic signed [15:0] r_rd_x, r_rd_y;
    logic [7:0]         r_rd_t;

    logic                accept_in;
    logic [8:0]          n_use;
    logic                city_we;
    logic [CITY_AW-1:0]  city_raddr;
    logic                tour_we;
    logic [TOUR_AW-1:0]  tour_waddr, tour_raddr;
    logic [7:0]          tour_wdata;
    logic [31:0]         mul_a, mul_b;
    logic [63:0]         mul_p;
    logic signed [16:0]  dx, dy;
    logic [15:0]         abs_dx, abs_dy;
    logic [29:0]         n_sq_rt, sq_trial, n_sq_rem;
    logic                sq_ge;
    logic [64:0]         div_rt;
    logic                div_ge;
    logic [63:0]         n_rem;
    logic [19:0]         n_q;
    logic [15:0]         q_frac;
    logic [40:0]         st_sum;
    logic signed [42:0]  nc;
    logic [39:0]         nc_clamp;
    logic signed [41:0]  dcost;
    logic [39:0]         pw_lhs, pw_rhs;

    assign accept_in  = i_in_valid && o_in_ready;
    assign o_in_ready = (r_state == S_IDLE);
    assign o_out_valid = r_out_valid;

    always_comb begin
        if (r_city_count < 9'd4) begin
            n_use = 9'd4;
        end else if (r_city_count > 9'(MAX_CITIES)) begin
            n_use = 9'(MAX_CITIES);
        end else begin
            n_use = r_city_count;
        end
    end

    // memories
    assign city_we = accept_in && (i_action == ACT_LOAD);

    always_comb begin
        city_raddr = '0;
        if (r_state == S_ST_RD) begin
            city_raddr = (r_i == 9'd0 || r_i == n_use) ? '0 : r_i[CITY_AW-1:0];
        end else if (r_state == S_SW_CRD) begin
            city_raddr = r_t[r_k];
        end
    end

    always_ff @(posedge i_clk) begin
        if (city_we) begin
            mem_x[i_city_index] <= i_coord_x;
            mem_y[i_city_index] <= i_coord_y;
        end
        r_rd_x <= mem_x[city_raddr];
        r_rd_y <= mem_y[city_raddr];
    end

    assign tour_raddr = TOUR_AW'({1'b0, r_pos} - 9'd1 + {7'd0, r_k});

    always_comb begin
        tour_we    = 1'b0;
        tour_waddr = '0;
        tour_wdata = '0;
        unique case (r_state)
            S_ST_SUM: begin
                tour_we    = 1'b1;
                tour_waddr = TOUR_AW'(r_i - 9'd1);
                tour_wdata = 8'(r_i - 9'd1);
            end
            S_ST_END: begin
                tour_we    = 1'b1;
                tour_waddr = TOUR_AW'(n_use);
            end
            S_AP1: begin
                tour_we    = 1'b1;
                tour_waddr = TOUR_AW'({1'b0, r_pos});
                tour_wdata = r_t[2];
            end
            S_AP2: begin
                tour_we    = 1'b1;
                tour_waddr = TOUR_AW'({1'b0, r_pos} + 9'd1);
                tour_wdata = r_t[1];
            end
            default: begin
                tour_we = 1'b0;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (tour_we) begin
            mem_tour[tour_waddr] <= tour_wdata;
        end
        r_rd_t <= mem_tour[tour_raddr];
    end

    // shared multiplier
    assign dx = {r_ux[15], r_ux} - {r_vx[15], r_vx};
    assign dy = {r_uy[15], r_uy} - {r_vy[15], r_vy};
    assign abs_dx = dx[16] ? 16'(-dx) : dx[15:0];
    assign abs_dy = dy[16] ? 16'(-dy) : dy[15:0];

    always_comb begin
        mul_a = '0;
        mul_b = '0;
        unique case (r_state)
            S_E_MX:   begin mul_a = {16'd0, abs_dx}; mul_b = {16'd0, abs_dx}; end
            S_E_MY:   begin mul_a = {16'd0, abs_dy}; mul_b = {16'd0, abs_dy}; end
            S_PW_MUL: begin mul_a = r_e; mul_b = {7'd0, r_sq_res}; end
            S_PW_INT: begin mul_a = r_e; mul_b = BASE_Q24; end
            S_DEC1:   begin mul_a = r_temp[31:0]; mul_b = r_decay; end
            S_DEC2:   begin mul_a = r_temp[63:32]; mul_b = r_decay; end
            default:  begin mul_a = '0; mul_b = '0; end
        endcase
    end
    assign mul_p = 64'(mul_a) * 64'(mul_b);

    // square root step
    assign n_sq_rt  = {r_sq_rem[27:0], r_sq_op[49:48]};
    assign sq_trial = {3'd0, r_sq_res, 2'b01};
    assign sq_ge    = (n_sq_rt >= sq_trial);
    assign n_sq_rem = sq_ge ? (n_sq_rt - sq_trial) : n_sq_rt;

    // division step
    assign div_rt = {r_rem, r_m[39]};
    assign div_ge = div_rt[64] || (div_rt[63:0] >= r_temp);
    assign n_rem  = div_ge ? (div_rt[63:0] - r_temp) : div_rt[63:0];
    assign n_q    = {r_q[18:0], div_ge};
    assign q_frac = r_q[15:0];

    assign st_sum   = {1'b0, r_acc} + {16'd0, r_sq_res};
    assign nc       = $signed({3'd0, r_cost}) + 43'(r_dsum);
    assign nc_clamp = nc[42] ? '0 : (nc[41:40] != 2'd0) ? COST_MAX : nc[39:0];
    assign dcost    = $signed({2'd0, r_cost}) - $signed({2'd0, nc_clamp});
    assign pw_lhs   = r_neg ? {PERCENT, 24'd0} + 40'd0 : 40'(r_e) * 40'(PERCENT);
    assign pw_rhs   = r_neg ? 40'(r_rnd) * 40'(r_e) : {9'd0, r_rnd, 24'd0};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state      <= S_IDLE;
            r_out_valid  <= 1'b0;
            r_city_count <= RST_CITY_COUNT;
            r_init_temp  <= RST_INIT_TEMP;
            r_decay      <= RST_DECAY;
            r_cost       <= '0;
            r_best       <= COST_MAX;
            r_temp       <= '0;
            r_q          <= '0;
            r_sq_cnt     <= '0;
        end else begin
            if (i_cfg_we) begin
                unique case (i_cfg_index)
                    CFG_CITY_COUNT: r_city_count <= i_cfg_data[8:0];
                    CFG_INIT_TEMP:  r_init_temp  <= i_cfg_data;
                    CFG_DECAY:      r_decay      <= i_cfg_data;
                    default:        r_decay      <= r_decay;
                endcase
            end

            if (r_state == S_DONE && (!r_out_valid || i_out_ready)) begin
                r_out_valid <= 1'b1;
            end else if (i_out_ready) begin
                r_out_valid <= 1'b0;
            end

            unique case (r_state)
                S_IDLE: begin
                    if (accept_in) begin
                        r_pos     <= i_swap_position;
                        r_rnd     <= i_random_percent;
                        r_res_acc <= 1'b0;
                        r_res_bad <= 1'b0;
                        r_i       <= '0;
                        r_k       <= '0;
                        r_acc     <= '0;
                        r_dsum    <= '0;
                        if (i_action == ACT_START) begin
                            r_state <= S_ST_RD;
                        end else if (i_action == ACT_STEP) begin
                            if (i_swap_position == 8'd0 ||
                                {1'b0, i_swap_position} > n_use - 9'd3) begin
                                r_res_bad <= 1'b1;
                                r_state   <= S_DONE;
                            end else begin
                                r_state <= S_SW_TRD;
                            end
                        end else begin
                            r_state <= S_DONE;
                        end
                    end
                end
                S_DONE: begin
                    if (!r_out_valid || i_out_ready) begin
                        o_accepted     <= r_res_acc;
                        o_bad_position <= r_res_bad;
                        o_tour_cost    <= r_cost;
                        o_least_cost   <= r_best;
                        r_state        <= S_IDLE;
                    end
                end
                S_ST_RD: begin
                    r_state <= S_ST_CAP;
                end
                S_ST_CAP: begin
                    r_vx <= r_rd_x;
                    r_vy <= r_rd_y;
                    if (r_i == 9'd0) begin
                        r_ux    <= r_rd_x;
                        r_uy    <= r_rd_y;
                        r_i     <= 9'd1;
                        r_state <= S_ST_RD;
                    end else begin
                        r_ret   <= S_ST_SUM;
                        r_state <= S_E_MX;
                    end
                end
                S_ST_SUM: begin
                    r_acc <= st_sum[40] ? COST_MAX : st_sum[39:0];
                    r_ux  <= r_vx;
                    r_uy  <= r_vy;
                    if (r_i == n_use) begin
                        r_state <= S_ST_END;
                    end else begin
                        r_i     <= r_i + 9'd1;
                        r_state <= S_ST_RD;
                    end
                end
                S_ST_END: begin
                    r_cost  <= r_acc;
                    r_temp  <= {r_init_temp, 32'd0};
                    r_best  <= COST_MAX;
                    r_state <= S_DONE;
                end
                S_SW_TRD: begin
                    r_state <= S_SW_TCAP;
                end
                S_SW_TCAP: begin
                    r_t[r_k] <= r_rd_t;
                    r_k      <= r_k + 2'd1;
                    r_state  <= (r_k == 2'd3) ? S_SW_CRD : S_SW_TRD;
                end
                S_SW_CRD: begin
                    r_state <= S_SW_CCAP;
                end
                S_SW_CCAP: begin
                    r_cx[r_k] <= r_rd_x;
                    r_cy[r_k] <= r_rd_y;
                    r_k       <= r_k + 2'd1;
                    r_state   <= (r_k == 2'd3) ? S_SW_ESET : S_SW_CRD;
                end
                S_SW_ESET: begin
                    unique case (r_k)
                        2'd0: begin
                            r_ux <= r_cx[0]; r_uy <= r_cy[0];
                            r_vx <= r_cx[2]; r_vy <= r_cy[2];
                        end
                        2'd1: begin
                            r_ux <= r_cx[1]; r_uy <= r_cy[1];
                            r_vx <= r_cx[3]; r_vy <= r_cy[3];
                        end
                        2'd2: begin
                            r_ux <= r_cx[0]; r_uy <= r_cy[0];
                            r_vx <= r_cx[1]; r_vy <= r_cy[1];
                        end
                        default: begin
                            r_ux <= r_cx[2]; r_uy <= r_cy[2];
                            r_vx <= r_cx[3]; r_vy <= r_cy[3];
                        end
                    endcase
                    r_ret   <= S_SW_EACC;
                    r_state <= S_E_MX;
                end
                S_SW_EACC: begin
                    if (r_k[1]) begin
                        r_dsum <= r_dsum - $signed({3'd0, r_sq_res});
                    end else begin
                        r_dsum <= r_dsum + $signed({3'd0, r_sq_res});
                    end
                    r_k     <= r_k + 2'd1;
                    r_state <= (r_k == 2'd3) ? S_SW_NC : S_SW_ESET;
                end
                S_SW_NC: begin
                    r_next <= nc_clamp;
                    if (nc_clamp < r_best) begin
                        r_best <= nc_clamp;
                    end
                    r_neg   <= dcost[41];
                    r_dzero <= (dcost == 42'sd0);
                    r_m     <= dcost[41] ? 40'(-dcost) : dcost[39:0];
                    r_state <= S_SW_CHK;
                end
                S_SW_CHK: begin
                    r_rem     <= '0;
                    r_q       <= '0;
                    r_div_cnt <= '0;
                    if (r_temp == 64'd0) begin
                        if ((!r_neg && !r_dzero) || (r_dzero && r_rnd < PERCENT)) begin
                            r_state <= S_AP1;
                        end else begin
                            r_state <= S_DEC1;
                        end
                    end else if (r_neg && r_rnd == 7'd0) begin
                        r_state <= S_AP1;
                    end else begin
                        r_state <= S_DIV;
                    end
                end
                S_DIV: begin
                    r_rem     <= n_rem;
                    r_m       <= {r_m[38:0], 1'b0};
                    r_div_cnt <= r_div_cnt + 7'd1;
                    if (n_q >= Q_CAP) begin
                        r_q     <= Q_CAP;
                        r_state <= S_DIV_END;
                    end else begin
                        r_q <= n_q;
                        if (r_div_cnt == 7'd95) begin
                            r_state <= S_DIV_END;
                        end
                    end
                end
                S_DIV_END: begin
                    r_e    <= ONE_Q24;
                    r_root <= BASE_Q24[25:0];
                    r_b    <= 4'd15;
                    if (!r_neg) begin
                        r_state <= (r_q[19:16] != 4'd0) ? S_AP1 : S_PW_SQ;
                    end else begin
                        r_state <= (r_q >= Q_CAP) ? S_DEC1 : S_PW_SQ;
                    end
                end
                S_PW_SQ: begin
                    r_sq_op  <= {r_root, 24'd0};
                    r_sq_rem <= '0;
                    r_sq_res <= '0;
                    r_sq_cnt <= '0;
                    r_ret    <= S_PW_MUL;
                    r_state  <= S_SQ;
                end
                S_PW_MUL: begin
                    r_root <= {1'b0, r_sq_res};
                    if (q_frac[r_b]) begin
                        r_e <= mul_p[55:24];
                    end
                    if (r_b == 4'd0) begin
                        r_kk    <= r_q[18:16];
                        r_state <= S_PW_INT;
                    end else begin
                        r_b     <= r_b - 4'd1;
                        r_state <= S_PW_SQ;
                    end
                end
                S_PW_INT: begin
                    if (r_kk == 3'd0) begin
                        r_state <= S_PW_CMP;
                    end else begin
                        r_e  <= mul_p[55:24];
                        r_kk <= r_kk - 3'd1;
                    end
                end
                S_PW_CMP: begin
                    r_state <= (pw_lhs > pw_rhs) ? S_AP1 : S_DEC1;
                end
                S_AP1: begin
                    r_state <= S_AP2;
                end
                S_AP2: begin
                    r_cost    <= r_next;
                    r_res_acc <= 1'b1;
                    r_state   <= S_DEC1;
                end
                S_DEC1: begin
                    r_prod  <= mul_p;
                    r_state <= S_DEC2;
                end
                S_DEC2: begin
                    r_temp  <= mul_p + {32'd0, r_prod[63:32]};
                    r_state <= S_DONE;
                end
                S_E_MX: begin
                    r_sq    <= mul_p[33:0];
                    r_state <= S_E_MY;
                end
                S_E_MY: begin
                    r_sq_op  <= {r_sq + mul_p[33:0], 16'd0};
                    r_sq_rem <= '0;
                    r_sq_res <= '0;
                    r_sq_cnt <= '0;
                    r_state  <= S_SQ;
                end
                S_SQ: begin
                    r_sq_op  <= {r_sq_op[47:0], 2'b00};
                    r_sq_rem <= n_sq_rem;
                    r_sq_res <= {r_sq_res[23:0], sq_ge};
                    r_sq_cnt <= r_sq_cnt + 5'd1;
                    if (r_sq_cnt == 5'd24) begin
                        r_state <= r_ret;
                    end
                end
                default: begin
                    r_state <= S_IDLE;
                end
            endcase
        end
    end

    a_sqrt_count: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_state == S_SQ |-> r_sq_cnt <= 5'd24)
        else $error("square root ran past its last step");

    a_quot_cap: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_q <= Q_CAP)
        else $error("quotient above cap");

    a_acc_not_bad: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid |-> !(o_accepted && o_bad_position))
        else $error("bad position request reported as accepted");

    a_least_le_cost: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && o_accepted) |-> o_least_cost <= o_tour_cost)
        else $error("accepted cost below least cost");

endmodule
